// File: src/velocity_command_pid_limiter_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the velocity command PID limiter
// Each macro places one concurrent assertion. It checks only in simulation
// and is empty when the code is synthesized.
// ----------------------------------------------------------------------------
`ifndef VELOCITY_COMMAND_PID_LIMITER_DEFINES_SVH
`define VELOCITY_COMMAND_PID_LIMITER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define VCPL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vcpl assertion failed");
// Next-cycle implication, checked outside reset.
`define VCPL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vcpl assertion failed");
`else
`define VCPL_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define VCPL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: src/vcpl_pkg.sv
// ----------------------------------------------------------------------------
// vcpl_pkg
// Shared types, codes and helpers of the velocity command PID limiter.
// ----------------------------------------------------------------------------
package vcpl_pkg;

    // Fraction bits of the gains and of the turn weight.
    localparam int GAIN_FRAC = 16;

    // Mode codes. Codes above stop act as stop.
    localparam logic [2:0] MODE_WANDER       = 3'd0;
    localparam logic [2:0] MODE_REACH        = 3'd1;
    localparam logic [2:0] MODE_ROTATE       = 3'd2;
    localparam logic [2:0] MODE_FINAL_ROTATE = 3'd3;
    localparam logic [2:0] MODE_STOP         = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_KP_GAIN      = 3'd0;
    localparam logic [2:0] CFG_KI_GAIN      = 3'd1;
    localparam logic [2:0] CFG_KD_GAIN      = 3'd2;
    localparam logic [2:0] CFG_BODY_RADIUS  = 3'd3;
    localparam logic [2:0] CFG_SPEED_LIMIT  = 3'd4;
    localparam logic [2:0] CFG_TURN_LIMIT   = 3'd5;
    localparam logic [2:0] CFG_TURN_WEIGHT  = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [19:0] RST_KP_GAIN     = 20'd9830;
    localparam logic [19:0] RST_KI_GAIN     = 20'd2949;
    localparam logic [19:0] RST_KD_GAIN     = 20'd98;
    localparam logic [13:0] RST_BODY_RADIUS = 14'd1229;
    localparam logic [13:0] RST_SPEED_LIMIT = 14'd1229;
    localparam logic [13:0] RST_TURN_LIMIT  = 14'd2144;
    localparam logic [15:0] RST_TURN_WEIGHT = 16'd9830;

    typedef struct packed {
        logic [19:0] kp_gain;
        logic [19:0] ki_gain;
        logic [19:0] kd_gain;
        logic [13:0] body_radius;
        logic [13:0] speed_limit;
        logic [13:0] turn_limit;
        logic [15:0] turn_speed_weight;
    } t_cfg;

    // Divide by 2^GAIN_FRAC, rounding half up (floor of x + one half).
    function automatic logic signed [40-GAIN_FRAC:0] round_gain(
        input logic signed [40:0] x
    );
        logic signed [40:0] y;
        y = x + (41'sd1 <<< (GAIN_FRAC - 1));
        return y[40:GAIN_FRAC];
    endfunction

endpackage

// File: src/velocity_command_pid_limiter.sv
// ----------------------------------------------------------------------------
// velocity_command_pid_limiter
// Per-tick turn PID with clamping and obstacle-limited forward speed command.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_in_valid / o_in_ready) carries one word per control
// tick: mode, guide speed, guide turn rate and nearest path distance. The
// output channel (o_out_valid / i_out_ready) returns one word per input word:
// the limited forward speed command and the clamped turn command, in order.
// A word is taken into an input register, computed in one pass and written
// to an output register, from which its result is shown. One word per cycle
// is sustained while the receiver keeps i_out_ready high; the limit is the
// turn state feedback loop. When the receiver stalls, the result holds in
// the output register and one more word waits in the input register; then
// o_in_ready drops until the stall clears. Reset clears both registers'
// valid flags, zeroes the PID state and loads the register defaults.
// Configuration registers are written through i_cfg_we / i_cfg_index /
// i_cfg_data, by the user only while the block is idle; the block itself
// does not enforce this.
// ----------------------------------------------------------------------------
`include "velocity_command_pid_limiter_defines.svh"

module velocity_command_pid_limiter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Input word channel.
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [2:0]          i_mode,
    input  logic signed [15:0]  i_guide_speed,
    input  logic signed [15:0]  i_guide_turn,
    input  logic [17:0]         i_path_min_distance,
    // Result word channel.
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [13:0]         o_speed_command,
    output logic signed [14:0]  o_turn_command,
    // Configuration write port.
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [19:0]         i_cfg_data
);

    vcpl_pkg::t_cfg w_cfg;

    // Input register.
    logic               r_in_vld;
    logic [2:0]         r_mode;
    logic signed [15:0] r_guide_speed;
    logic signed [15:0] r_guide_turn;
    logic [17:0]        r_path;

    // Output register.
    logic               r_out_vld;
    logic [13:0]        r_speed;
    logic signed [14:0] r_turn;

    logic               w_fire;
    logic signed [15:0] w_turn_prev;
    logic signed [14:0] w_turn_next;
    logic [13:0]        w_speed;

    // A word moves from the input register to the output register when the
    // output register is empty or is being emptied in this cycle. The PID
    // state is updated at the same edge, so the next word sees it at once.
    assign w_fire     = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || w_fire;

    vcpl_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    vcpl_turn_pid u_pid (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_update     (w_fire),
        .i_mode       (r_mode),
        .i_guide_turn (r_guide_turn),
        .i_cfg        (w_cfg),
        .o_turn_prev  (w_turn_prev),
        .o_turn_next  (w_turn_next)
    );

    vcpl_speed_limit u_speed (
        .i_mode              (r_mode),
        .i_guide_speed       (r_guide_speed),
        .i_path_min_distance (r_path),
        .i_turn_prev         (w_turn_prev),
        .i_cfg               (w_cfg),
        .o_speed             (w_speed)
    );

    // Valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (w_fire) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_mode        <= i_mode;
            r_guide_speed <= i_guide_speed;
            r_guide_turn  <= i_guide_turn;
            r_path        <= i_path_min_distance;
        end
        if (w_fire) begin
            r_speed <= w_speed;
            r_turn  <= w_turn_next;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_speed_command = r_speed;
    assign o_turn_command  = r_turn;

    // A word leaving the input register always shows up as a result.
    `VCPL_ASSERT_NEXT(a_fire_gives_result, i_clk, i_rst_n, w_fire, r_out_vld)
    // A shown turn command lies within the turn limit.
    `VCPL_ASSERT_IMP(a_turn_in_limit, i_clk, i_rst_n, r_out_vld,
        ($signed({r_turn[14], r_turn}) <= $signed({2'd0, w_cfg.turn_limit}))
        && ($signed({r_turn[14], r_turn}) >= -$signed({2'd0, w_cfg.turn_limit})))
    // A shown speed command never exceeds the speed limit.
    `VCPL_ASSERT_IMP(a_speed_in_limit, i_clk, i_rst_n, r_out_vld,
        r_speed <= w_cfg.speed_limit)

endmodule

// File: src/vcpl_cfg_regs.sv
// ----------------------------------------------------------------------------
// vcpl_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module vcpl_cfg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [19:0]         i_cfg_data,
    output vcpl_pkg::t_cfg      o_cfg
);

    vcpl_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp_gain           <= vcpl_pkg::RST_KP_GAIN;
            r_cfg.ki_gain           <= vcpl_pkg::RST_KI_GAIN;
            r_cfg.kd_gain           <= vcpl_pkg::RST_KD_GAIN;
            r_cfg.body_radius       <= vcpl_pkg::RST_BODY_RADIUS;
            r_cfg.speed_limit       <= vcpl_pkg::RST_SPEED_LIMIT;
            r_cfg.turn_limit        <= vcpl_pkg::RST_TURN_LIMIT;
            r_cfg.turn_speed_weight <= vcpl_pkg::RST_TURN_WEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                vcpl_pkg::CFG_KP_GAIN:     r_cfg.kp_gain           <= i_cfg_data;
                vcpl_pkg::CFG_KI_GAIN:     r_cfg.ki_gain           <= i_cfg_data;
                vcpl_pkg::CFG_KD_GAIN:     r_cfg.kd_gain           <= i_cfg_data;
                vcpl_pkg::CFG_BODY_RADIUS: r_cfg.body_radius       <= i_cfg_data[13:0];
                vcpl_pkg::CFG_SPEED_LIMIT: r_cfg.speed_limit       <= i_cfg_data[13:0];
                vcpl_pkg::CFG_TURN_LIMIT:  r_cfg.turn_limit        <= i_cfg_data[13:0];
                vcpl_pkg::CFG_TURN_WEIGHT: r_cfg.turn_speed_weight <= i_cfg_data[15:0];
                default: begin
                    // Writes to unused indexes are dropped.
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: src/vcpl_turn_pid.sv
// ----------------------------------------------------------------------------
// vcpl_turn_pid
// Incremental PID on the turn command with clamping, holding the loop state.
// ----------------------------------------------------------------------------
module vcpl_turn_pid (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_update,
    input  logic [2:0]          i_mode,
    input  logic signed [15:0]  i_guide_turn,
    input  vcpl_pkg::t_cfg      i_cfg,
    output logic signed [15:0]  o_turn_prev,
    output logic signed [14:0]  o_turn_next
);

    logic signed [15:0] r_turn_out;
    logic signed [15:0] r_target;
    logic signed [17:0] r_err_prev;
    logic signed [17:0] r_err_prev2;

    logic signed [15:0] w_target;
    logic signed [17:0] w_e0;
    logic signed [18:0] w_dp;
    logic signed [19:0] w_dd;
    logic signed [39:0] w_pp;
    logic signed [38:0] w_pi;
    logic signed [40:0] w_pd;
    logic signed [40:0] w_sum;
    logic signed [24:0] w_delta;
    logic signed [25:0] w_turn;
    logic signed [25:0] w_lim;
    logic signed [25:0] w_clamped;

    always_comb begin
        case (i_mode)
            vcpl_pkg::MODE_WANDER,
            vcpl_pkg::MODE_ROTATE:       w_target = i_guide_turn;
            vcpl_pkg::MODE_FINAL_ROTATE: w_target = r_target;
            default:                     w_target = '0;
        endcase
    end

    assign w_e0 = {{2{w_target[15]}}, w_target} - {{2{r_turn_out[15]}}, r_turn_out};
    assign w_dp = {w_e0[17], w_e0} - {r_err_prev[17], r_err_prev};
    assign w_dd = {{2{w_e0[17]}}, w_e0} - {r_err_prev[17], r_err_prev, 1'b0}
                + {{2{r_err_prev2[17]}}, r_err_prev2};

    // Three gain products side by side, summed and rounded once.
    assign w_pp  = $signed({1'b0, i_cfg.kp_gain}) * w_dp;
    assign w_pi  = $signed({1'b0, i_cfg.ki_gain}) * w_e0;
    assign w_pd  = $signed({1'b0, i_cfg.kd_gain}) * w_dd;
    assign w_sum = {w_pp[39], w_pp} + {{2{w_pi[38]}}, w_pi} + w_pd;
    assign w_delta = vcpl_pkg::round_gain(w_sum);

    assign w_turn = {{10{r_turn_out[15]}}, r_turn_out} + {w_delta[24], w_delta};
    assign w_lim  = {12'd0, i_cfg.turn_limit};

    always_comb begin
        if (w_turn >= w_lim) begin
            w_clamped = w_lim;
        end else if (w_turn <= -w_lim) begin
            w_clamped = -w_lim;
        end else begin
            w_clamped = w_turn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn_out  <= '0;
            r_target    <= '0;
            r_err_prev  <= '0;
            r_err_prev2 <= '0;
        end else if (i_update) begin
            r_turn_out  <= w_clamped[15:0];
            r_target    <= w_target;
            r_err_prev2 <= r_err_prev;
            r_err_prev  <= w_e0;
        end
    end

    assign o_turn_prev = r_turn_out;
    assign o_turn_next = w_clamped[14:0];

endmodule

// File: src/vcpl_speed_limit.sv
// ----------------------------------------------------------------------------
// vcpl_speed_limit
// Forward speed command: target less radius and turn loss, then clamped.
// ----------------------------------------------------------------------------
module vcpl_speed_limit (
    input  logic [2:0]          i_mode,
    input  logic signed [15:0]  i_guide_speed,
    input  logic [17:0]         i_path_min_distance,
    input  logic signed [15:0]  i_turn_prev,
    input  vcpl_pkg::t_cfg      i_cfg,
    output logic [13:0]         o_speed
);

    logic signed [15:0] w_target;
    logic signed [18:0] w_free;
    logic signed [18:0] w_prot;
    logic signed [15:0] w_abs_full;
    logic [14:0]        w_abs;
    logic [30:0]        w_wprod;
    logic signed [24:0] w_wround;
    logic signed [18:0] w_speed;
    logic signed [18:0] w_lim;
    logic signed [18:0] w_s1;
    logic signed [18:0] w_s2;
    logic signed [18:0] w_s3;

    always_comb begin
        case (i_mode)
            vcpl_pkg::MODE_WANDER,
            vcpl_pkg::MODE_ROTATE: w_target = i_guide_speed;
            default:               w_target = '0;
        endcase
    end

    assign w_free = $signed({1'b0, i_path_min_distance}) - $signed({5'd0, i_cfg.body_radius});
    assign w_prot = w_free[18] ? '0 : w_free;

    // The turn loss uses the turn command from before this word's update.
    assign w_abs_full = i_turn_prev[15] ? -i_turn_prev : i_turn_prev;
    assign w_abs      = w_abs_full[14:0];
    assign w_wprod    = w_abs * i_cfg.turn_speed_weight;
    assign w_wround   = vcpl_pkg::round_gain($signed({10'd0, w_wprod}));

    assign w_speed = {{3{w_target[15]}}, w_target} - $signed({5'd0, i_cfg.body_radius})
                   - $signed({4'd0, w_wround[14:0]});
    assign w_lim   = $signed({5'd0, i_cfg.speed_limit});

    assign w_s1 = (w_speed >= w_lim)  ? w_lim  : w_speed;
    assign w_s2 = (w_s1    >= w_prot) ? w_prot : w_s1;
    assign w_s3 = w_s2[18] ? '0 : w_s2;

    assign o_speed = w_s3[13:0];

endmodule

// File: dv/velocity_command_pid_limiter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// velocity_command_pid_limiter_tb
// Self-checking bench for the turn PID and speed limiter. Control ticks go in
// over the input channel and a cycle-free model of the block works out the
// speed and turn commands each one should give. Result words are checked
// field by field in order. The run covers a directed table, then random
// ticks under six register settings, with random idling on both channels
// and long receiver stalls.
// ----------------------------------------------------------------------------
module velocity_command_pid_limiter_tb;
    import vcpl_pkg::*;

    // Mode codes the block does not define; they must behave like stop.
    localparam logic [2:0] MODE_SPARE_5 = 3'd5;
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int LONG_STALL      = 64;
    localparam int PHASES          = 6;
    localparam int WORDS_PER_PHASE = 138;
    // Idling regimes change after this many words (sender) or results
    // (receiver): first a lazy receiver, then a lazy sender, then full rate.
    localparam int REGIME_A_END    = 283;
    localparam int REGIME_B_END    = 566;

    // One control tick as it crosses the input channel.
    typedef struct packed {
        logic [2:0]         mode;
        logic signed [15:0] guide_speed;
        logic signed [15:0] guide_turn;
        logic [17:0]        path_min_distance;
    } tick_t;

    // One pair of commands as it crosses the output channel.
    typedef struct packed {
        logic [13:0]        speed_command;
        logic signed [14:0] turn_command;
    } cmd_t;

    // A row of the directed table. Where known is set, the expected commands
    // are typed in; otherwise the model supplies them.
    typedef struct packed {
        logic [2:0]         mode;
        logic signed [15:0] guide_speed;
        logic signed [15:0] guide_turn;
        logic [17:0]        path_min_distance;
        logic               known;
        logic [13:0]        exp_speed;
        logic signed [14:0] exp_turn;
    } dir_row_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [2:0]         i_mode;
    logic signed [15:0] i_guide_speed;
    logic signed [15:0] i_guide_turn;
    logic [17:0]        i_path_min_distance;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [13:0]        o_speed_command;
    logic signed [14:0] o_turn_command;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_index;
    logic [19:0]        i_cfg_data;

    // Model copy of the registers and of the PID state.
    t_cfg               cfg_copy;
    logic signed [15:0] steer_cmd_q;
    logic signed [15:0] steer_goal_q;
    logic signed [17:0] steer_err1_q;
    logic signed [17:0] steer_err2_q;

    // Commands still owed by the block, oldest first.
    cmd_t               pending_cmds[$];
    logic [19:0]        reg_plan[7];

    int                 words_sent   = 0;
    int                 results_seen = 0;
    int                 err_count    = 0;
    int                 quiet_cycles = 0;

    // The first five rows start from the reset state, so their commands can
    // be read off directly: nothing moves until a wander tick with a full
    // turn target, which saturates both commands at their reset limits.
    dir_row_t dir_rows[22] = '{
        '{MODE_STOP,         16'sh7FFF, 16'sh8000, 18'h00000, 1'b1, 14'd0,    15'sd0},
        '{MODE_SPARE_5,      16'sh8000, 16'sh7FFF, 18'h3FFFF, 1'b1, 14'd0,    15'sd0},
        '{MODE_SPARE_7,      16'sh7FFF, 16'sh7FFF, 18'h3FFFF, 1'b1, 14'd0,    15'sd0},
        '{MODE_REACH,        16'sh7FFF, 16'sh8000, 18'h3FFFF, 1'b1, 14'd0,    15'sd0},
        '{MODE_WANDER,       16'sh7FFF, 16'sh7FFF, 18'h3FFFF, 1'b1, 14'd1229, 15'sd2144},
        '{MODE_FINAL_ROTATE, 16'sh7FFF, 16'sh8000, 18'h3FFFF, 1'b0, 14'd0,    15'sd0},
        '{MODE_FINAL_ROTATE, 16'sh0000, 16'sh0000, 18'h01000, 1'b0, 14'd0,    15'sd0},
        '{MODE_ROTATE,       16'sh8000, 16'sh8000, 18'h00000, 1'b0, 14'd0,    15'sd0},
        '{MODE_ROTATE,       16'sh7FFF, 16'sh8000, 18'h3FFFF, 1'b0, 14'd0,    15'sd0},
        '{MODE_FINAL_ROTATE, 16'sh7FFF, 16'sh7FFF, 18'h3FFFF, 1'b0, 14'd0,    15'sd0},
        '{MODE_WANDER,       16'sh4000, 16'sh0000, 18'h01000, 1'b0, 14'd0,    15'sd0},
        '{MODE_WANDER,       16'sh7FFF, 16'sh0000, 18'h004CD, 1'b0, 14'd0,    15'sd0},
        '{MODE_WANDER,       16'sh7FFF, 16'sh0000, 18'h003E8, 1'b0, 14'd0,    15'sd0},
        '{MODE_WANDER,       16'sh7FFF, 16'sh0000, 18'h007D0, 1'b0, 14'd0,    15'sd0},
        '{MODE_WANDER,       16'sh0800, 16'sh0200, 18'h3FFFF, 1'b0, 14'd0,    15'sd0},
        '{MODE_STOP,         16'sh5555, 16'shAAAA, 18'h2AAAA, 1'b0, 14'd0,    15'sd0},
        '{MODE_WANDER,       16'shAAAA, 16'sh5555, 18'h15555, 1'b0, 14'd0,    15'sd0},
        '{MODE_SPARE_6,      16'sh1234, 16'shEDCB, 18'h3FFFF, 1'b0, 14'd0,    15'sd0},
        '{MODE_REACH,        16'sh2000, 16'sh0400, 18'h08000, 1'b0, 14'd0,    15'sd0},
        '{MODE_ROTATE,       16'sh0000, 16'shF800, 18'h08000, 1'b0, 14'd0,    15'sd0},
        '{MODE_FINAL_ROTATE, 16'sh3000, 16'sh0000, 18'h08000, 1'b0, 14'd0,    15'sd0},
        '{MODE_WANDER,       16'sh1800, 16'sh0000, 18'h02000, 1'b0, 14'd0,    15'sd0}
    };

    velocity_command_pid_limiter i_dut (
        .i_clk,
        .i_rst_n,
        .i_in_valid,
        .o_in_ready,
        .i_mode,
        .i_guide_speed,
        .i_guide_turn,
        .i_path_min_distance,
        .o_out_valid,
        .i_out_ready,
        .o_speed_command,
        .o_turn_command,
        .i_cfg_we,
        .i_cfg_index,
        .i_cfg_data
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Divide a Q.16 product by 2^16, rounding half up. An arithmetic shift
    // floors, which matches for negative values too.
    function automatic longint q16_round(input longint x);
        return (x + 64'sd32768) >>> 16;
    endfunction

    // Works out the commands for one tick and advances the PID state.
    function automatic cmd_t compute_commands(input tick_t w);
        longint goal_speed, radius, room, prev_turn, mag, speed;
        longint goal_turn, e0, e1, e2, delta, turn;
        longint kp, ki, kd, weight, slim, lim;
        cmd_t   c;
        kp     = cfg_copy.kp_gain;
        ki     = cfg_copy.ki_gain;
        kd     = cfg_copy.kd_gain;
        weight = cfg_copy.turn_speed_weight;
        slim   = cfg_copy.speed_limit;
        lim    = cfg_copy.turn_limit;
        radius = cfg_copy.body_radius;

        // The mode picks the speed target and what turn target is held.
        // Final rotate keeps whatever turn target was held before.
        case (w.mode)
            MODE_WANDER, MODE_ROTATE: begin
                goal_speed   = $signed(w.guide_speed);
                steer_goal_q = w.guide_turn;
            end
            MODE_FINAL_ROTATE: begin
                goal_speed = 0;
            end
            default: begin
                goal_speed   = 0;
                steer_goal_q = '0;
            end
        endcase

        // Speed is reduced by the turn command of the previous tick, before
        // this tick's PID update.
        room = w.path_min_distance;
        room = room - radius;
        if (room < 0) room = 0;
        prev_turn = steer_cmd_q;
        mag       = (prev_turn < 0) ? -prev_turn : prev_turn;
        speed     = goal_speed - radius - q16_round(mag * weight);
        if (speed >= slim) speed = slim;
        if (speed >= room) speed = room;
        if (speed < 0) speed = 0;

        // Incremental PID: the change in command comes from the current
        // error and the two before it.
        goal_turn = steer_goal_q;
        e2        = steer_err2_q;
        e1        = steer_err1_q;
        e0        = goal_turn - prev_turn;
        delta     = q16_round(kp * (e0 - e1) + ki * e0 + kd * (e0 - 2 * e1 + e2));
        turn      = prev_turn + delta;
        if (turn <= -lim) turn = -lim;
        if (turn >= lim) turn = lim;

        steer_err2_q = e1[17:0];
        steer_err1_q = e0[17:0];
        steer_cmd_q  = turn[15:0];

        c.speed_command = speed[13:0];
        c.turn_command  = turn[14:0];
        return c;
    endfunction

    // Offers one word on the input channel and waits for it to be taken.
    // Called right after a rising edge. Valid stays high on return so that
    // back-to-back words need no gap.
    task automatic put_word(input tick_t w, input bit use_given, input cmd_t given);
        cmd_t predicted;
        int   idle_pct;
        idle_pct = (words_sent < REGIME_A_END) ? 17 : (words_sent < REGIME_B_END) ? 62 : 0;
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_mode              <= w.mode;
        i_guide_speed       <= w.guide_speed;
        i_guide_turn        <= w.guide_turn;
        i_path_min_distance <= w.path_min_distance;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        // The model runs on every tick so that its state keeps step, even
        // where the table supplies the expected commands.
        predicted = compute_commands(w);
        pending_cmds.push_back(use_given ? given : predicted);
        words_sent++;
    endtask

    // Stops offering words and waits until every owed result has come back.
    task automatic drain_words();
        i_in_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
    endtask

    // Writes every register from reg_plan, one per cycle, and mirrors each
    // write into the model with the register's width applied.
    task automatic program_regs();
        for (int r = CFG_KP_GAIN; r <= CFG_TURN_WEIGHT; r++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= 3'(r);
            i_cfg_data  <= reg_plan[r];
            @(posedge i_clk);
            case (3'(r))
                CFG_KP_GAIN:     cfg_copy.kp_gain           = reg_plan[r];
                CFG_KI_GAIN:     cfg_copy.ki_gain           = reg_plan[r];
                CFG_KD_GAIN:     cfg_copy.kd_gain           = reg_plan[r];
                CFG_BODY_RADIUS: cfg_copy.body_radius       = reg_plan[r][13:0];
                CFG_SPEED_LIMIT: cfg_copy.speed_limit       = reg_plan[r][13:0];
                CFG_TURN_LIMIT:  cfg_copy.turn_limit        = reg_plan[r][13:0];
                CFG_TURN_WEIGHT: cfg_copy.turn_speed_weight = reg_plan[r][15:0];
                default: ;
            endcase
        end
        i_cfg_we <= 1'b0;
    endtask

    // Main stimulus: reset, the directed table, then six register settings
    // with a block of random ticks each.
    initial begin
        tick_t t;
        cmd_t  given;
        cmd_t  none;
        i_rst_n             = 1'b0;
        i_in_valid          = 1'b0;
        i_mode              = MODE_STOP;
        i_guide_speed       = '0;
        i_guide_turn        = '0;
        i_path_min_distance = '0;
        i_cfg_we            = 1'b0;
        i_cfg_index         = CFG_KP_GAIN;
        i_cfg_data          = '0;
        cfg_copy = '{RST_KP_GAIN, RST_KI_GAIN, RST_KD_GAIN, RST_BODY_RADIUS,
                     RST_SPEED_LIMIT, RST_TURN_LIMIT, RST_TURN_WEIGHT};
        steer_cmd_q  = '0;
        steer_goal_q = '0;
        steer_err1_q = '0;
        steer_err2_q = '0;
        none         = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: every mode including the undefined codes, the
        // extremes of each field, final rotate keeping a held target, and
        // obstacle distances below, at and just above the body radius.
        foreach (dir_rows[n]) begin
            t.mode              = dir_rows[n].mode;
            t.guide_speed       = dir_rows[n].guide_speed;
            t.guide_turn        = dir_rows[n].guide_turn;
            t.path_min_distance = dir_rows[n].path_min_distance;
            given.speed_command = dir_rows[n].exp_speed;
            given.turn_command  = dir_rows[n].exp_turn;
            put_word(t, dir_rows[n].known, given);
        end

        for (int phase = 1; phase <= PHASES; phase++) begin
            // Registers change only once the block has nothing in flight.
            drain_words();
            case (phase)
                1: begin
                    // Reset values but a zero turn limit: the turn command
                    // must stay at zero whatever the target.
                    reg_plan[CFG_KP_GAIN]     = RST_KP_GAIN;
                    reg_plan[CFG_KI_GAIN]     = RST_KI_GAIN;
                    reg_plan[CFG_KD_GAIN]     = RST_KD_GAIN;
                    reg_plan[CFG_BODY_RADIUS] = RST_BODY_RADIUS;
                    reg_plan[CFG_SPEED_LIMIT] = RST_SPEED_LIMIT;
                    reg_plan[CFG_TURN_LIMIT]  = '0;
                    reg_plan[CFG_TURN_WEIGHT] = RST_TURN_WEIGHT;
                end
                2: foreach (reg_plan[r]) reg_plan[r] = '0;
                // All ones, wider than the narrow registers, so the upper
                // bits must be dropped.
                3: foreach (reg_plan[r]) reg_plan[r] = '1;
                5: begin
                    // A plausible tuning: gains below one, moderate sizes.
                    reg_plan[CFG_KP_GAIN]     = 20'($urandom_range(0, 65535));
                    reg_plan[CFG_KI_GAIN]     = 20'($urandom_range(0, 65535));
                    reg_plan[CFG_KD_GAIN]     = 20'($urandom_range(0, 16383));
                    reg_plan[CFG_BODY_RADIUS] = 20'($urandom_range(0, 4095));
                    reg_plan[CFG_SPEED_LIMIT] = 20'($urandom_range(0, 16383));
                    reg_plan[CFG_TURN_LIMIT]  = 20'($urandom_range(0, 16383));
                    reg_plan[CFG_TURN_WEIGHT] = 20'($urandom_range(0, 65535));
                end
                default: foreach (reg_plan[r]) reg_plan[r] = 20'($urandom);
            endcase
            program_regs();

            // Random ticks. Half the speed and turn targets are small so the
            // limits and the PID do not simply saturate; distances are
            // spread over the full range, the usual range and the radius.
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                t.mode = ($urandom_range(0, 9) == 0)
                       ? 3'($urandom_range(MODE_SPARE_5, MODE_SPARE_7))
                       : 3'($urandom_range(MODE_WANDER, MODE_STOP));
                t.guide_speed = $urandom_range(0, 1) ? 16'($urandom)
                              : 16'($urandom_range(0, 16383) - 4096);
                t.guide_turn  = $urandom_range(0, 1) ? 16'($urandom)
                              : 16'($urandom_range(0, 8191) - 4096);
                case ($urandom_range(0, 2))
                    0:       t.path_min_distance = 18'($urandom);
                    1:       t.path_min_distance = 18'($urandom_range(0, 16383));
                    default: t.path_min_distance = 18'(cfg_copy.body_radius)
                                                 + 18'($urandom_range(0, 64));
                endcase
                put_word(t, 1'b0, none);
            end
        end

        // Let the last results come back, then allow a few more cycles for
        // anything unexpected to show up.
        drain_words();
        repeat (8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Receiver: takes results with random idling, and twice holds off for a
    // long stretch so the block fills up and drops its input ready while the
    // sender keeps offering words.
    initial begin
        int next_stall;
        int pct;
        i_out_ready = 1'b0;
        next_stall  = 100;
        forever begin
            @(posedge i_clk);
            if (results_seen >= next_stall) begin
                i_out_ready <= 1'b0;
                repeat (LONG_STALL) @(posedge i_clk);
                next_stall += 380;
            end else begin
                pct = (results_seen < REGIME_A_END) ? 62 : (results_seen < REGIME_B_END) ? 17 : 0;
                i_out_ready <= ($urandom_range(0, 99) >= pct);
            end
        end
    end

    // Checks each accepted result word against the oldest owed commands.
    always @(posedge i_clk) begin
        cmd_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen <= results_seen + 1;
            if (pending_cmds.size() == 0) begin
                $error("result word with no commands pending: speed %0d turn %0d",
                       o_speed_command, o_turn_command);
                err_count++;
            end else begin
                want = pending_cmds.pop_front();
                if (o_speed_command !== want.speed_command) begin
                    $error("speed_command: expected %0d, got %0d",
                           want.speed_command, o_speed_command);
                    err_count++;
                end
                if (o_turn_command !== want.turn_command) begin
                    $error("turn_command: expected %0d, got %0d",
                           $signed(want.turn_command), o_turn_command);
                    err_count++;
                end
            end
        end
    end

    // Ends a hung run: too many cycles in a row with no word moving.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
